### rtl/core/word_hash_probe_table_assert.svh
// Assertion macros used by the checker of the word hash probe table.
// Each macro takes a label, the clock, the active-low reset, the two sides and a message.
`ifndef WORD_HASH_PROBE_TABLE_ASSERT_SVH
`define WORD_HASH_PROBE_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WHPT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WHPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/whpt_pkg.sv
// Package of the word hash probe table: widths, status codes, key type and
// the command and status structs between controller and datapath. No dependencies.
package whpt_pkg;

  localparam int TABLE_SIZE_DEF = 26;
  localparam int KEY_LO_W       = 64;
  localparam int KEY_MID_W      = 64;
  localparam int KEY_HI_W       = 24;
  localparam int STATUS_W       = 2;
  localparam int SLOT_W         = 5;
  localparam int CMP_W          = 5;
  localparam int LETTER_W       = 5;
  localparam int HOME_TBL_N     = 32;

  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_KEY   = 2'd3;

  // Input mode codes.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  // A full 19-byte key.
  typedef struct packed {
    logic [KEY_HI_W-1:0]  hi;
    logic [KEY_MID_W-1:0] mid;
    logic [KEY_LO_W-1:0]  lo;
  } key_t;

  // Where the reported slot and comparison count come from.
  typedef enum logic [2:0] {
    SRC_A_HIT,   // slot and count of the address stage
    SRC_A_MISS,  // slot zero, count of the address stage
    SRC_C_HIT,   // slot and count of the compare stage
    SRC_C_MISS,  // slot zero, count of the compare stage
    SRC_ZERO     // slot zero, count zero
  } fin_src_t;

  typedef struct packed {
    logic                load;
    logic                advance;
    logic                ins_write;
    logic                finish;
    logic [STATUS_W-1:0] fin_status;
    fin_src_t            fin_src;
  } whpt_cmd_t;

  typedef struct packed {
    logic bad_key;
    logic search;
    logic a_used;
    logic a_last;
    logic c_used;
    logic c_hit;
    logic c_last;
  } whpt_stat_t;

endpackage

### rtl/core/whpt_ctrl.sv
// Controller of the word hash probe table: sequences load, probing and result.
// Depends on whpt_pkg.
module whpt_ctrl
  import whpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  whpt_stat_t stat,
  output whpt_cmd_t  cmd,
  output logic       busy,
  output logic       out_valid
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_SEARCH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands to the datapath.
  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = 1'b0;
    cmd            = '0;
    cmd.fin_status = ST_DONE;
    cmd.fin_src    = SRC_ZERO;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        priority if (stat.bad_key) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_BAD_KEY;
          cmd.fin_src    = SRC_ZERO;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (stat.search) begin
          // Issue the first key read; it is compared in the next cycle.
          cmd.advance = 1'b1;
          state_nxt   = S_SEARCH;
        end else if (!stat.a_used) begin
          cmd.ins_write  = 1'b1;
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_DONE;
          cmd.fin_src    = SRC_A_HIT;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (stat.a_last) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_FULL;
          cmd.fin_src    = SRC_A_MISS;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_SEARCH: begin
        priority if (!stat.c_used) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_NOT_FOUND;
          cmd.fin_src    = SRC_C_MISS;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (stat.c_hit) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_DONE;
          cmd.fin_src    = SRC_C_HIT;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (stat.c_last) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_NOT_FOUND;
          cmd.fin_src    = SRC_C_MISS;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### rtl/core/whpt_datapath.sv
// Datapath of the word hash probe table: probe address generation, slot valid
// bits, key memory, key compare and result registers. Depends on whpt_pkg.
module whpt_datapath
  import whpt_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_mode,
  input  logic [KEY_LO_W-1:0]  in_key_lo,
  input  logic [KEY_MID_W-1:0] in_key_mid,
  input  logic [KEY_HI_W-1:0]  in_key_hi,
  input  logic                 cfg_we,
  input  logic                 cfg_probe_mode,
  input  whpt_cmd_t            cmd,
  output whpt_stat_t           stat,
  output logic [STATUS_W-1:0]  out_status,
  output logic [SLOT_W-1:0]    out_slot,
  output logic [CMP_W-1:0]     out_comparisons
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam logic [IDX_W:0]   SIZE_EXT = (IDX_W+1)'(TABLE_SIZE);
  localparam logic [IDX_W-1:0] LAST_CNT = IDX_W'(TABLE_SIZE - 1);

  // Home slot of each letter offset, reduced modulo the table size.
  logic [IDX_W-1:0] home_tbl [HOME_TBL_N];
  for (genvar k = 0; k < HOME_TBL_N; k++) begin : g_home
    assign home_tbl[k] = IDX_W'(k % TABLE_SIZE);
  end

  logic                probe_mode_r;
  key_t                key_r;
  logic                search_r;
  logic                bad_r;
  logic [IDX_W-1:0]    slot_a_r;
  logic [IDX_W-1:0]    cnt_a_r;
  logic [IDX_W-1:0]    delta_r;
  logic [IDX_W-1:0]    slot_c_r;
  logic [IDX_W-1:0]    cnt_c_r;
  logic                used_c_r;
  key_t                rd_key_r;
  logic [TABLE_SIZE-1:0] used_r;
  key_t                key_mem [TABLE_SIZE];
  logic [STATUS_W-1:0] res_status_r;
  logic [SLOT_W-1:0]   res_slot_r;
  logic [CMP_W-1:0]    res_cmp_r;

  logic [7:0]          first_byte;
  logic [7:0]          letter_diff;
  logic                letter_ok;
  logic [IDX_W-1:0]    home_in;
  logic [IDX_W:0]      slot_sum;
  logic [IDX_W-1:0]    slot_step;
  logic [IDX_W:0]      delta_sum;
  logic [IDX_W-1:0]    delta_step;
  logic [IDX_W-1:0]    delta_nxt;
  key_t                key_in;

  // Key decode: first byte must be a lowercase letter.
  assign first_byte  = in_key_lo[7:0];
  assign letter_ok   = (first_byte >= CHAR_LOWER_A) && (first_byte <= CHAR_LOWER_Z);
  assign letter_diff = first_byte - CHAR_LOWER_A;
  assign home_in     = home_tbl[letter_diff[LETTER_W-1:0]];
  assign key_in      = '{hi: in_key_hi, mid: in_key_mid, lo: in_key_lo};

  // Next probe slot: add the step and wrap once, both sides are below the size.
  assign slot_sum  = {1'b0, slot_a_r} + {1'b0, delta_r};
  assign slot_step = (slot_sum >= SIZE_EXT) ? IDX_W'(slot_sum - SIZE_EXT) : slot_sum[IDX_W-1:0];

  // Quadratic probing grows the step by two each probe (odd numbers give squares).
  assign delta_sum  = {1'b0, delta_r} + (IDX_W+1)'(2);
  assign delta_step = (delta_sum >= SIZE_EXT) ? IDX_W'(delta_sum - SIZE_EXT)
                                              : delta_sum[IDX_W-1:0];
  assign delta_nxt  = probe_mode_r ? delta_step : delta_r;

  // Configuration register and slot valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_mode_r <= 1'b0;
      used_r       <= '0;
    end else begin
      if (cfg_we) begin
        probe_mode_r <= cfg_probe_mode;
      end
      if (cmd.ins_write) begin
        used_r[slot_a_r] <= 1'b1;
      end
    end
  end

  // Request capture and probe stages.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r    <= key_in;
      search_r <= (in_mode == MODE_SEARCH);
      bad_r    <= !letter_ok;
      slot_a_r <= home_in;
      cnt_a_r  <= '0;
      delta_r  <= IDX_W'(1);
    end else if (cmd.advance) begin
      slot_a_r <= slot_step;
      cnt_a_r  <= cnt_a_r + IDX_W'(1);
      delta_r  <= delta_nxt;
    end
    if (cmd.advance) begin
      slot_c_r <= slot_a_r;
      cnt_c_r  <= cnt_a_r;
      used_c_r <= used_r[slot_a_r];
    end
  end

  // Key memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.ins_write) begin
      key_mem[slot_a_r] <= key_r;
    end
    if (cmd.advance) begin
      rd_key_r <= key_mem[slot_a_r];
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_status_r <= cmd.fin_status;
      unique case (cmd.fin_src)
        SRC_A_HIT: begin
          res_slot_r <= SLOT_W'(slot_a_r);
          res_cmp_r  <= CMP_W'(cnt_a_r);
        end
        SRC_A_MISS: begin
          res_slot_r <= '0;
          res_cmp_r  <= CMP_W'(cnt_a_r);
        end
        SRC_C_HIT: begin
          res_slot_r <= SLOT_W'(slot_c_r);
          res_cmp_r  <= CMP_W'(cnt_c_r);
        end
        SRC_C_MISS: begin
          res_slot_r <= '0;
          res_cmp_r  <= CMP_W'(cnt_c_r);
        end
        default: begin
          res_slot_r <= '0;
          res_cmp_r  <= '0;
        end
      endcase
    end
  end

  // Status to the controller.
  assign stat.bad_key = bad_r;
  assign stat.search  = search_r;
  assign stat.a_used  = used_r[slot_a_r];
  assign stat.a_last  = (cnt_a_r == LAST_CNT);
  assign stat.c_used  = used_c_r;
  assign stat.c_hit   = (rd_key_r == key_r);
  assign stat.c_last  = (cnt_c_r == LAST_CNT);

  assign out_status      = res_status_r;
  assign out_slot        = res_slot_r;
  assign out_comparisons = res_cmp_r;

endmodule

### rtl/core/word_hash_probe_table.sv
// Top level of the word hash probe table: controller plus datapath.
// Depends on whpt_pkg, whpt_ctrl and whpt_datapath.
//
// Usage. A request (in_mode, in_key_lo, in_key_mid, in_key_hi) is taken at a
// clock edge where start is high and busy is low. in_mode selects insert or
// search. One result (out_status, out_slot, out_comparisons) follows per
// request, shown for exactly one cycle with out_valid high; the receiver must
// take it then, it cannot stall the block. busy is already low in that cycle,
// so the next request may be taken while the result is on the ports.
// Probing. Probes run one per cycle. A search takes a registered key memory
// read before each compare, so it returns later than an insert that ends on
// the same probe. A key whose first byte is not a lowercase letter is
// rejected before any probe. One request is in flight at a time.
// Configuration. cfg_probe_mode (0 linear, 1 quadratic) is written when
// cfg_valid and cfg_ready are high; cfg_ready is high whenever busy is low.
// Reset. Synchronous rst_n empties the table and selects linear probing.
module word_hash_probe_table
  import whpt_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_mode,
  input  logic [KEY_LO_W-1:0]  in_key_lo,
  input  logic [KEY_MID_W-1:0] in_key_mid,
  input  logic [KEY_HI_W-1:0]  in_key_hi,
  output logic                 out_valid,
  output logic [STATUS_W-1:0]  out_status,
  output logic [SLOT_W-1:0]    out_slot,
  output logic [CMP_W-1:0]     out_comparisons,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_probe_mode
);

  whpt_cmd_t  cmd;
  whpt_stat_t stat;
  logic       cfg_we;

  // Configuration is taken only between requests.
  assign cfg_ready = !busy;
  assign cfg_we    = cfg_valid && cfg_ready;

  whpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  whpt_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mode         (in_mode),
    .in_key_lo       (in_key_lo),
    .in_key_mid      (in_key_mid),
    .in_key_hi       (in_key_hi),
    .cfg_we          (cfg_we),
    .cfg_probe_mode  (cfg_probe_mode),
    .cmd             (cmd),
    .stat            (stat),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_comparisons (out_comparisons)
  );

endmodule

### rtl/core/whpt_checker.sv
// Port-level checker of the word hash probe table and its bind statement.
// Depends on whpt_pkg and word_hash_probe_table_assert.svh.
`include "word_hash_probe_table_assert.svh"

module whpt_checker
  import whpt_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input logic [STATUS_W-1:0] out_status,
  input logic [SLOT_W-1:0]   out_slot,
  input logic [CMP_W-1:0]    out_comparisons
);

  // A result is only shown once the block has finished its request.
  `WHPT_ASSERT_SAME(a_result_when_idle, clk, rst_n, out_valid, !busy, "result while busy")

  // A taken request keeps the block busy in the next cycle.
  `WHPT_ASSERT_NEXT(a_busy_after_start, clk, rst_n, start && !busy, busy, "not busy after request")

  // Results never come in consecutive cycles.
  `WHPT_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_valid, !out_valid, "back-to-back results")

  // A rejected key reports slot and count of zero.
  `WHPT_ASSERT_SAME(a_bad_key_zero, clk, rst_n, out_valid && (out_status == ST_BAD_KEY), (out_slot == '0) && (out_comparisons == '0), "bad key result not zero")

endmodule

bind word_hash_probe_table whpt_checker u_whpt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_slot        (out_slot),
  .out_comparisons (out_comparisons)
);

### bench/tb.sv
// Self-checking testbench for word_hash_probe_table: directed probing cases, then random traffic.
// Holds its own model of the slot store and compares every result against it.
// Depends on whpt_pkg and the word_hash_probe_table RTL.
module tb;
  import whpt_pkg::*;

  localparam int TABLE_SIZE   = TABLE_SIZE_DEF;
  localparam int KEY_W        = $bits(key_t);
  localparam int SEGMENTS     = 12;
  localparam int SEGMENT_LEN  = 152;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 40;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [CMP_W-1:0]    cmp;
  } result_t;

  typedef struct packed {
    logic mode;
    key_t key;
  } request_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_mode = MODE_INSERT;
  logic [KEY_LO_W-1:0]  in_key_lo = '0;
  logic [KEY_MID_W-1:0] in_key_mid = '0;
  logic [KEY_HI_W-1:0]  in_key_hi = '0;
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [SLOT_W-1:0]    out_slot;
  logic [CMP_W-1:0]     out_comparisons;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_probe_mode = 1'b0;

  // Model of the slot store and the probing register.
  logic    slot_taken [TABLE_SIZE];
  key_t    slot_key   [TABLE_SIZE];
  int      slots_filled = 0;
  logic    quad_probing = 1'b0;

  result_t pending_results [$];
  int      fail_count = 0;
  int      cycle_count = 0;

  // Sender pacing.
  logic    bursty = 1'b1;
  int      burst_left = 0;

  // A spilled key kept from the linear phase for the quadratic phase.
  key_t    z_spill;

  word_hash_probe_table #(.TABLE_SIZE(TABLE_SIZE)) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_key_lo       (in_key_lo),
    .in_key_mid      (in_key_mid),
    .in_key_hi       (in_key_hi),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_comparisons (out_comparisons),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_probe_mode  (cfg_probe_mode)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    foreach (slot_taken[n]) slot_taken[n] = 1'b0;
  end

  // Works out the result of one request and applies it to the slot store.
  function automatic result_t predict_table_op(input logic mode, input key_t key);
    result_t res;
    logic [7:0] lead;
    int home;
    int s;
    lead = key.lo[7:0];
    res = '{ST_BAD_KEY, '0, '0};
    if (lead < CHAR_LOWER_A || lead > CHAR_LOWER_Z) return res;
    home = int'(lead - CHAR_LOWER_A) % TABLE_SIZE;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      s = (home + (quad_probing ? i * i : i)) % TABLE_SIZE;
      if (mode == MODE_INSERT) begin
        if (!slot_taken[s]) begin
          slot_taken[s] = 1'b1;
          slot_key[s] = key;
          slots_filled++;
          res = '{ST_DONE, SLOT_W'(s), CMP_W'(i)};
          return res;
        end
      end else if (!slot_taken[s]) begin
        res = '{ST_NOT_FOUND, '0, CMP_W'(i)};
        return res;
      end else if (slot_key[s] === key) begin
        res = '{ST_DONE, SLOT_W'(s), CMP_W'(i)};
        return res;
      end
    end
    res = '{(mode == MODE_SEARCH) ? ST_NOT_FOUND : ST_FULL, '0, CMP_W'(TABLE_SIZE - 1)};
    return res;
  endfunction

  function automatic key_t make_key(input logic [KEY_LO_W-1:0] lo,
                                    input logic [KEY_MID_W-1:0] mid,
                                    input logic [KEY_HI_W-1:0] hi);
    key_t k;
    k.lo = lo;
    k.mid = mid;
    k.hi = hi;
    return k;
  endfunction

  // A random key with the given first byte; a third of them are zero padded words.
  function automatic key_t random_word(input logic [7:0] lead);
    key_t k;
    int len;
    k.lo = {$urandom, $urandom};
    k.mid = {$urandom, $urandom};
    k.hi = KEY_HI_W'($urandom);
    if ($urandom_range(0, 2) == 0) begin
      len = $urandom_range(1, 19);
      for (int b = len; b < 19; b++) k[8*b +: 8] = 8'h00;
    end
    k.lo[7:0] = lead;
    return k;
  endfunction

  // Half the letters come from the ends of the alphabet so that clusters and wrap-round form.
  function automatic logic [7:0] random_letter();
    if ($urandom_range(0, 1) == 0)
      return 8'(CHAR_LOWER_A + $urandom_range(0, 25));
    else if ($urandom_range(0, 1) == 0)
      return 8'(CHAR_LOWER_A + $urandom_range(0, 1));
    else
      return 8'(CHAR_LOWER_Z - $urandom_range(0, 1));
  endfunction

  function automatic key_t stored_key();
    int s;
    do s = $urandom_range(0, TABLE_SIZE - 1); while (!slot_taken[s]);
    return slot_key[s];
  endfunction

  // Mostly searches for stored keys and near misses, with some inserts and bad keys.
  function automatic request_t random_request();
    request_t req;
    int sel;
    int insert_pct;
    logic [7:0] bad;
    insert_pct = (slots_filled < TABLE_SIZE) ? 12 : 5;
    sel = $urandom_range(0, 99);
    req.mode = MODE_SEARCH;
    req.key = random_word(random_letter());
    if (sel < 6) begin
      do bad = 8'($urandom); while (bad >= CHAR_LOWER_A && bad <= CHAR_LOWER_Z);
      req.key.lo[7:0] = bad;
      req.mode = ($urandom_range(0, 1) == 0) ? MODE_INSERT : MODE_SEARCH;
    end else if (sel < 6 + insert_pct) begin
      req.mode = MODE_INSERT;
      if (slots_filled > 0 && $urandom_range(0, 3) == 0) req.key = stored_key();
    end else if (slots_filled > 0 && sel < 60) begin
      req.key = stored_key();
    end else if (slots_filled > 0 && sel < 75) begin
      req.key = stored_key();
      req.key[$urandom_range(8, KEY_W - 1)] ^= 1'b1;
    end
    return req;
  endfunction

  // Inserts a gap after a burst of requests when pacing is on.
  task automatic pace_sender();
    if (!bursty) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, TABLE_SIZE + 4)) @(posedge clk);
      else
        repeat ($urandom_range(1, 4)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  // Presents one request and holds it until the block takes it.
  task automatic send_request(input logic mode, input key_t key);
    start <= 1'b1;
    in_mode <= mode;
    in_key_lo <= key.lo;
    in_key_mid <= key.mid;
    in_key_hi <= key.hi;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pending_results.push_back(predict_table_op(mode, key));
    pace_sender();
  endtask

  // Stops sending and waits until every result is in and the block has settled.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TABLE_SIZE + 4) @(posedge clk);
  endtask

  task automatic write_probe_mode(input logic quad);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_probe_mode <= quad;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    quad_probing = quad;
  endtask

  // Search of the empty table, then first bytes outside the lowercase range, some just outside it.
  task automatic test_empty_and_bad_keys();
    logic [7:0] bad_lead [5];
    bad_lead[0] = 8'h00;
    bad_lead[1] = CHAR_LOWER_A - 8'd1;
    bad_lead[2] = CHAR_LOWER_Z + 8'd1;
    bad_lead[3] = CHAR_UPPER_A;
    bad_lead[4] = 8'hff;
    send_request(MODE_SEARCH, make_key({56'h0, CHAR_LOWER_A}, '0, '0));
    foreach (bad_lead[n])
      send_request(n[0] ? MODE_SEARCH : MODE_INSERT, random_word(bad_lead[n]));
    send_request(MODE_INSERT, make_key('1, '1, '1));
  endtask

  // Linear collisions, duplicates, a near miss in the padding and wrap-round past the end.
  task automatic test_linear_probing();
    key_t a_ones;
    key_t a_bare;
    key_t near;
    a_ones = make_key({56'hff_ffff_ffff_ffff, CHAR_LOWER_A}, '1, '1);
    a_bare = make_key({56'h0, CHAR_LOWER_A}, '0, '0);
    write_probe_mode(1'b0);
    send_request(MODE_INSERT, a_ones);
    send_request(MODE_INSERT, a_bare);
    send_request(MODE_SEARCH, a_ones);
    send_request(MODE_SEARCH, a_bare);
    near = a_bare;
    near.hi[KEY_HI_W-1] = 1'b1;
    send_request(MODE_SEARCH, near);
    send_request(MODE_INSERT, a_bare);
    send_request(MODE_SEARCH, a_bare);
    z_spill = random_word(CHAR_LOWER_Z);
    send_request(MODE_INSERT, make_key({56'h0, CHAR_LOWER_Z}, '0, '0));
    send_request(MODE_INSERT, z_spill);
    send_request(MODE_SEARCH, z_spill);
  endtask

  // Quadratic collisions on one letter, a miss after a few probes and a wrapped hit.
  task automatic test_quadratic_probing();
    key_t m_keys [3];
    write_probe_mode(1'b1);
    foreach (m_keys[n]) begin
      m_keys[n] = random_word(CHAR_LOWER_A + 8'd12);
      send_request(MODE_INSERT, m_keys[n]);
    end
    send_request(MODE_SEARCH, m_keys[2]);
    send_request(MODE_SEARCH, random_word(CHAR_LOWER_A + 8'd12));
    send_request(MODE_SEARCH, z_spill);
  endtask

  // Random requests in segments, each with its own probing setting and pacing.
  task automatic test_random_traffic();
    request_t req;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      write_probe_mode((seg < 2) ? seg[0] : 1'($urandom_range(0, 1)));
      bursty = (seg % 4 != 2);
      for (int n = 0; n < SEGMENT_LEN; n++) begin
        req = random_request();
        send_request(req.mode, req.key);
      end
    end
  endtask

  // Result checker: every strobed result must match the oldest expectation.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid !== 1'b0) begin
      got = {out_status, out_slot, out_comparisons};
      if (pending_results.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual status %0d slot %0d cmp %0d",
                   $time, got.status, got.slot, got.cmp);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (fail_count < MAX_REPORTS)
            $display("%0t: result mismatch, expected status %0d slot %0d cmp %0d, %s %0d %0d %0d",
                     $time, want.status, want.slot, want.cmp, "actual status slot cmp",
                     got.status, got.slot, got.cmp);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_bad_keys();
    test_linear_probing();
    test_quadratic_probing();
    test_random_traffic();
    wait_idle();
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
